>>> rtl/tgr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Touch gesture recognizer package
// Shared types, constants and event codes for the gesture recognizer.
// ----------------------------------------------------------------------------
package tgr_pkg;

  localparam int MaxTouches = 8;
  localparam int IdxW = $clog2(MaxTouches);
  localparam int CntW = $clog2(MaxTouches + 1);

  typedef logic [1:0] mode_t;
  localparam mode_t ModeDown = 2'd0;
  localparam mode_t ModeMove = 2'd1;
  localparam mode_t ModeUp   = 2'd2;
  localparam mode_t ModeTick = 2'd3;

  typedef logic [2:0] kind_t;
  localparam kind_t KindShortTap = 3'd0;
  localparam kind_t KindLongTap  = 3'd1;
  localparam kind_t KindLongEnd  = 3'd2;
  localparam kind_t KindPinch    = 3'd3;
  localparam kind_t KindPinchEnd = 3'd4;

  localparam logic [15:0] ScaleOne = 16'd256;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t RegLongTap = 2'd0;
  localparam reg_idx_t RegMove    = 2'd1;
  localparam reg_idx_t RegPinch   = 2'd2;

  // Request to the shared arithmetic unit.
  typedef enum logic [1:0] {
    OpSqrt = 2'd0,
    OpDiv  = 2'd1
  } op_t;

  typedef struct packed {
    logic        start;
    op_t         op;
    logic [33:0] a;   // radicand, or dividend
    logic [16:0] b;   // divisor
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [33:0] res;
  } alu_rsp_t;

endpackage : tgr_pkg
`default_nettype wire

>>> rtl/touch_gesture_recognizer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Touch gesture recognizer
// Tap, long tap and two-finger pinch detection over a compacted touch table.
// ----------------------------------------------------------------------------
// A tap move squares its offset against the move limit, and an up sweeps the table
// to compact it. Pinch start runs the 17-step square root; pinch moves run it too,
// plus the 34-step divide when the spread changes by more than the pinch limit,
// all in one shared unit. The result blocks new requests until taken.
// Synchronous reset clears all gesture state; the touch table is not cleared.
module touch_gesture_recognizer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: mode[1:0], pointer_id[6:2], pos_x[22:7], pos_y[38:23],
  // second_id[43:39], second_x[59:44], second_y[75:60], pointer_count[80:76]
  input  wire logic [87:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: event_kind[2:0], event_x[18:3], event_y[34:19], scale[50:35]
  output logic [55:0]      m_axis_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import tgr_pkg::*;

  typedef enum logic [9:0] {
    StIdle   = 10'b0000000001,
    StExec   = 10'b0000000010,
    StFind1  = 10'b0000000100,
    StFind2  = 10'b0000001000,
    StSqrt   = 10'b0000010000,
    StSqWait = 10'b0000100000,
    StDivW   = 10'b0001000000,
    StSweep  = 10'b0010000000,
    StOut    = 10'b0100000000,
    StMoveT  = 10'b1000000000
  } state_t;

  state_t state;

  logic [15:0] long_tap_ms, move_limit, pinch_limit;
  logic [4:0]  ids [MaxTouches];
  logic [15:0] xs  [MaxTouches];
  logic [15:0] ys  [MaxTouches];
  logic [CntW-1:0] count;
  logic tap_candidate, long_tap_fired, pinching;
  logic [15:0] start_x, start_y, held_ms;
  logic [16:0] last_spread;

  logic [1:0]  mode;
  logic [4:0]  id, id2, pcnt;
  logic [15:0] px, py, px2, py2;
  logic [CntW-1:0] rd, wr;
  logic [16:0] cur;
  logic pinch_start;

  logic [2:0]  o_kind;
  logic [15:0] o_x, o_y, o_s;

  alu_req_t req;
  alu_rsp_t rsp;

  tgr_alu u_alu (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  assign s_axis_tready = (state == StIdle) && !m_axis_tvalid;
  assign cfg_ready     = 1'b1;
  assign m_axis_tdata  = {5'd0, o_s, o_y, o_x, o_kind};

  // Pair distance terms from table entries 0 and 1.
  logic [15:0] pdx, pdy;
  assign pdx = (xs[0] > xs[1]) ? xs[0] - xs[1] : xs[1] - xs[0];
  assign pdy = (ys[0] > ys[1]) ? ys[0] - ys[1] : ys[1] - ys[0];

  // Tap move test terms.
  logic [15:0] tdx, tdy;
  assign tdx = (px > start_x) ? px - start_x : start_x - px;
  assign tdy = (py > start_y) ? py - start_y : start_y - py;

  // Squares share one multiplier, one per cycle.
  logic [15:0] mul_a;
  logic [31:0] mul_p;
  logic [33:0] acc;
  logic [1:0]  msel;
  assign mul_p = mul_a * mul_a;

  logic [16:0] diff;
  assign diff = (rsp.res[16:0] > last_spread) ? rsp.res[16:0] - last_spread
                                               : last_spread - rsp.res[16:0];

  logic [CntW-1:0] hit1, hit2;
  logic f1, f2;
  always_comb begin
    hit1 = '0; hit2 = '0; f1 = 1'b0; f2 = 1'b0;
    for (int i = MaxTouches - 1; i >= 0; i--) begin
      if (i < count && ids[i] == id)  begin f1 = 1'b1; hit1 = CntW'(i); end
      if (i < count && ids[i] == id2) begin f2 = 1'b1; hit2 = CntW'(i); end
    end
  end

  always_comb begin
    case (msel)
      2'd0:    mul_a = pdx;
      2'd1:    mul_a = pdy;
      2'd2:    mul_a = tdx;
      default: mul_a = tdy;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      m_axis_tvalid <= 1'b0;
      long_tap_ms <= 16'd500; move_limit <= 16'd160; pinch_limit <= 16'd160;
      count <= '0; tap_candidate <= 1'b0; long_tap_fired <= 1'b0;
      pinching <= 1'b0; start_x <= '0; start_y <= '0; held_ms <= '0;
      last_spread <= '0; req.start <= 1'b0;
    end else begin
      req.start <= 1'b0;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          RegLongTap: long_tap_ms <= cfg_data;
          RegMove:    move_limit  <= cfg_data;
          RegPinch:   pinch_limit <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        StIdle: if (s_axis_tvalid && s_axis_tready) begin
          mode <= s_axis_tdata[1:0];   id  <= s_axis_tdata[6:2];
          px   <= s_axis_tdata[22:7];  py  <= s_axis_tdata[38:23];
          id2  <= s_axis_tdata[43:39]; px2 <= s_axis_tdata[59:44];
          py2  <= s_axis_tdata[75:60]; pcnt <= s_axis_tdata[80:76];
          state <= StExec;
        end
        StExec: begin
          o_s <= ScaleOne;
          case (mode)
            ModeDown: begin
              if (count >= CntW'(MaxTouches)) state <= StIdle;
              else begin
                ids[count[IdxW-1:0]] <= id;
                xs[count[IdxW-1:0]]  <= px;
                ys[count[IdxW-1:0]]  <= py;
                count <= count + 1'b1;
                tap_candidate <= 1'b0; long_tap_fired <= 1'b0; pinching <= 1'b0;
                if (count == 0) begin
                  held_ms <= '0; tap_candidate <= 1'b1;
                  start_x <= px; start_y <= py; state <= StIdle;
                end else if (count == 1) begin
                  pinching <= 1'b1; pinch_start <= 1'b1; msel <= 2'd0;
                  state <= StSqrt;
                end else state <= StIdle;
              end
            end
            ModeMove: begin
              if (pinching && count >= 2) begin
                pinch_start <= 1'b0; state <= StFind1;
              end else if (tap_candidate && count == 1) begin
                msel <= 2'd2; state <= StMoveT;
              end else state <= StIdle;
            end
            ModeUp: begin
              if (!f1) state <= StIdle;
              else begin
                if (count == 1 && !pinching) begin
                  if (long_tap_fired) begin
                    o_kind <= KindLongEnd; o_x <= start_x; o_y <= start_y;
                    m_axis_tvalid <= 1'b1;
                  end else if (tap_candidate) begin
                    o_kind <= KindShortTap; o_x <= start_x; o_y <= start_y;
                    m_axis_tvalid <= 1'b1;
                  end
                  tap_candidate <= 1'b0; long_tap_fired <= 1'b0;
                end else if (pinching && count == 2) begin
                  pinching <= 1'b0;
                  o_kind <= KindPinchEnd; o_x <= '0; o_y <= '0;
                  m_axis_tvalid <= 1'b1;
                end
                rd <= '0; wr <= '0; state <= StSweep;
              end
            end
            default: begin
              state <= StIdle;
              if (tap_candidate && !pinching && !long_tap_fired) begin
                if (held_ms != 16'hFFFF) held_ms <= held_ms + 1'b1;
                if (((held_ms == 16'hFFFF) ? held_ms : held_ms + 1'b1) >= long_tap_ms)
                begin
                  long_tap_fired <= 1'b1; tap_candidate <= 1'b0;
                  o_kind <= KindLongTap; o_x <= start_x; o_y <= start_y;
                  m_axis_tvalid <= 1'b1;
                end
              end
            end
          endcase
        end
        StMoveT: begin
          // Dx squared first, then dy squared plus compare.
          if (msel == 2'd2) begin
            acc <= {2'b0, mul_p}; msel <= 2'd3;
          end else begin
            if (acc + {2'b0, mul_p} > {2'b0, 32'(move_limit) * 32'(move_limit)})
              tap_candidate <= 1'b0;
            state <= StIdle;
          end
        end
        StFind1: begin
          if (pcnt >= 5'd1 && f1) begin
            xs[hit1[IdxW-1:0]] <= px; ys[hit1[IdxW-1:0]] <= py;
          end
          state <= StFind2;
        end
        StFind2: begin
          if (pcnt >= 5'd2 && f2) begin
            xs[hit2[IdxW-1:0]] <= px2; ys[hit2[IdxW-1:0]] <= py2;
          end
          msel <= 2'd0; state <= StSqrt;
        end
        StSqrt: begin
          if (msel == 2'd0) begin
            acc <= {2'b0, mul_p}; msel <= 2'd1;
          end else begin
            req.start <= 1'b1; req.op <= OpSqrt;
            req.a <= acc + {2'b0, mul_p}; req.b <= '0;
            state <= StSqWait;
          end
        end
        StSqWait: if (rsp.done) begin
          cur <= rsp.res[16:0];
          o_x <= 16'((17'(xs[0]) + 17'(xs[1])) >> 1);
          o_y <= 16'((17'(ys[0]) + 17'(ys[1])) >> 1);
          o_kind <= KindPinch;
          if (pinch_start) begin
            last_spread <= rsp.res[16:0]; o_s <= ScaleOne; state <= StOut;
          end else if (diff <= {1'b0, pinch_limit}) state <= StIdle;
          else if (last_spread == 0) begin
            last_spread <= rsp.res[16:0]; o_s <= 16'hFFFF; state <= StOut;
          end else begin
            req.start <= 1'b1; req.op <= OpDiv;
            req.a <= {rsp.res[16:0], 8'd0} + 34'(last_spread >> 1);
            req.b <= last_spread;
            state <= StDivW;
          end
        end
        StDivW: if (rsp.done) begin
          o_s <= (rsp.res > 34'hFFFF) ? 16'hFFFF : rsp.res[15:0];
          last_spread <= cur; state <= StOut;
        end
        StOut: begin
          m_axis_tvalid <= 1'b1; state <= StIdle;
        end
        StSweep: begin
          if (rd >= count) begin
            count <= wr; state <= StIdle;
          end else begin
            if (ids[rd[IdxW-1:0]] != id) begin
              ids[wr[IdxW-1:0]] <= ids[rd[IdxW-1:0]];
              xs[wr[IdxW-1:0]]  <= xs[rd[IdxW-1:0]];
              ys[wr[IdxW-1:0]]  <= ys[rd[IdxW-1:0]];
              wr <= wr + 1'b1;
            end
            rd <= rd + 1'b1;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CntW'(MaxTouches))
    else $error("touch count exceeds table size");
  assert property (@(posedge clk) disable iff (rst) !(pinching && tap_candidate))
    else $error("pinch and tap modes both active");
  assert property (@(posedge clk) disable iff (rst)
    (state == StIdle && s_axis_tvalid && s_axis_tready) |=> state == StExec)
    else $error("accepted request not executed");
  assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");

endmodule : touch_gesture_recognizer_unit
`default_nettype wire

>>> rtl/tgr_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Shared iterative unit
// Bit-serial square root (one result bit per cycle) and restoring divide.
// ----------------------------------------------------------------------------
module tgr_alu (
  input  wire logic              clk,
  input  wire logic              rst,
  input  tgr_pkg::alu_req_t      req,
  output tgr_pkg::alu_rsp_t      rsp
);
  import tgr_pkg::*;

  logic        busy;
  logic        done;
  op_t         op;
  logic [5:0]  step;
  logic [33:0] work;     // remaining radicand / dividend bits
  logic [35:0] rem;      // partial remainder
  logic [33:0] root;     // root or quotient
  logic [16:0] dvs;

  logic [35:0] trial;
  logic [35:0] sh_rem;

  always_comb begin
    if (op == OpSqrt) begin
      sh_rem = {rem[33:0], work[33:32]};
      trial  = {root[33:0], 2'b01};
    end else begin
      sh_rem = {rem[34:0], work[33]};
      trial  = {19'd0, dvs};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        work <= req.a;
        dvs  <= req.b;
        rem  <= '0;
        root <= '0;
        step <= (req.op == OpSqrt) ? 6'd17 : 6'd34;
      end else if (busy) begin
        if (op == OpSqrt) work <= {work[31:0], 2'b00};
        else              work <= {work[32:0], 1'b0};
        if (sh_rem >= trial) begin
          rem  <= sh_rem - trial;
          root <= {root[32:0], 1'b1};
        end else begin
          rem  <= sh_rem;
          root <= {root[32:0], 1'b0};
        end
        step <= step - 6'd1;
        if (step == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.done = done;
    rsp.res  = root;
  end

endmodule : tgr_alu
`default_nettype wire
